FILE: design/deficit_round_robin_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// Deficit round robin scheduler assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef DEFICIT_ROUND_ROBIN_SCHEDULER_TOP_MACROS_SVH
`define DEFICIT_ROUND_ROBIN_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define DRR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define DRR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/drr_pkg.sv
// ----------------------------------------------------------------------------
// Deficit round robin package
// Payload types, codes and fixed constants.
// ----------------------------------------------------------------------------
package drr_pkg;

    localparam int VISIT_W = 13;
    localparam logic [VISIT_W-1:0] VISIT_LIMIT = 13'd4096;
    localparam int ALU_W = 34;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUANTUM0 = 3'd0,
        CFG_QUANTUM1 = 3'd1,
        CFG_QUANTUM2 = 3'd2,
        CFG_QUANTUM3 = 3'd3,
        CFG_SWITCH   = 3'd4,
        CFG_TOL      = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        OP_ENQ   = 1'b0,
        OP_SERVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_ENQ    = 2'd0,
        KIND_DROP   = 2'd1,
        KIND_SERVED = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE, S_ENQ, S_VISIT, S_ARR, S_FIT, S_WAIT, S_DSUB, S_VSIZE,
        S_QADD, S_ROT, S_MOVE, S_WRAP, S_DONE
    } t_state;

    typedef struct packed {
        logic        op;
        logic [1:0]  queue_index;
        logic [15:0] pkt_len;
        logic [31:0] arrival_time;
    } t_drr_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  served_queue;
        logic [31:0] served_arrival;
        logic [31:0] wait_time;
        logic        was_retried;
        logic [31:0] now_time;
    } t_drr_rsp;

    // Stored packet: retry flag, arrival, size.
    typedef struct packed {
        logic        retry;
        logic [31:0] arr;
        logic [15:0] size;
    } t_pkt;

endpackage

FILE: design/drr_if.sv
// ----------------------------------------------------------------------------
// Deficit round robin channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface drr_req_if;
    logic              valid;
    logic              ready;
    drr_pkg::t_drr_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface drr_rsp_if;
    logic              valid;
    logic              ready;
    drr_pkg::t_drr_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/drr_alu.sv
// ----------------------------------------------------------------------------
// Deficit round robin shared adder
// Signed add with a compare of the sum against a third operand.
// ----------------------------------------------------------------------------
module drr_alu (
    input  logic signed [drr_pkg::ALU_W-1:0] i_a,
    input  logic signed [drr_pkg::ALU_W-1:0] i_b,
    input  logic signed [drr_pkg::ALU_W-1:0] i_c,
    output logic signed [drr_pkg::ALU_W-1:0] o_sum,
    output logic                             o_lt
);
    assign o_sum = i_a + i_b;
    assign o_lt  = (o_sum < i_c);
endmodule

FILE: design/drr_mem.sv
// ----------------------------------------------------------------------------
// Deficit round robin packet store
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module drr_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int WIDTH = 49
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

FILE: design/deficit_round_robin_scheduler_top.sv
// ----------------------------------------------------------------------------
// Deficit round robin scheduler
// Packet queues served by deficit round robin in virtual time.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake     Payload
// i_req     in   valid/ready   op, queue_index, pkt_len, arrival_time
// o_rsp     out  valid/ready   kind, served_queue, served_arrival,
//                              wait_time, was_retried, now_time
// i_cfg_*   in   write enable  register index, 16 bit data
//
// An enqueue writes the store; a serve with nothing pending goes straight to
// its result. Any other serve walks the queues, passing an empty queue or an
// unarrived head, crediting the queue's quantum and rotating a head that does
// not fit, and serving the first head that fits; each move adds the switch
// cost, once more when it wraps. After 4096 visits the walk stops.
// Ready returns once the sequencer is idle. Time and deficit sums use one
// shared 34 bit adder/comparator. Reset is synchronous and clears all
// control state; the packet store needs no clearing. A stalled result holds
// in the output register; the next request is taken while it waits.
// ----------------------------------------------------------------------------
module deficit_round_robin_scheduler_top #(
    parameter int NUM_QUEUES  = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    drr_req_if.sink                         i_req,
    drr_rsp_if.source                       o_rsp,
    input  logic                            i_cfg_we,
    input  logic [drr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [drr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    localparam int QW   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW   = $clog2(QUEUE_DEPTH);
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int SLOTS = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW   = $clog2(SLOTS + 1);
    localparam int MW   = $bits(drr_pkg::t_pkt);
    localparam int AL   = drr_pkg::ALU_W;

    // Sequencer
    drr_pkg::t_state r_state, n_state;

    // Configuration
    logic [15:0] r_quant [4];
    logic [15:0] r_sw;
    logic [7:0]  r_tol;

    // Queue state
    logic [PW-1:0]       r_head [NUM_QUEUES];
    logic [CW-1:0]       r_cnt  [NUM_QUEUES];
    logic signed [31:0]  r_def  [NUM_QUEUES];
    logic [31:0]         r_vt;
    logic [QW-1:0]       r_cur;
    logic [TW-1:0]       r_pend;
    logic [drr_pkg::VISIT_W-1:0] r_visits;

    // Held request and result
    drr_pkg::t_drr_req r_req;
    drr_pkg::t_kind    r_kind;
    logic [1:0]        r_sq;
    logic [31:0]       r_sarr;
    logic [31:0]       r_wait;
    logic              r_retry;
    logic              r_out_valid;
    drr_pkg::t_drr_rsp r_rsp;

    // Datapath
    logic signed [AL-1:0] w_a, w_b, w_c, w_sum;
    logic                 w_lt;
    logic                 w_we, w_re;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [MW-1:0]        w_wdata, w_rdata;
    drr_pkg::t_pkt        w_pkt;
    logic [QW-1:0]        w_q;
    logic [PW:0]          w_tail_sum;
    logic [PW-1:0]        w_tail, w_head_nx;
    logic [AW-1:0]        w_slot_head, w_slot_tail;
    logic                 w_full, w_drop, w_wrap, w_accept, w_out_free;
    logic [31:0]          w_tsat;
    logic signed [31:0]   w_dsat;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_pkt      = drr_pkg::t_pkt'(w_rdata);

    // Queue in hand: the enqueue target, else the walk position
    assign w_q = (r_state == drr_pkg::S_ENQ) ? QW'(r_req.queue_index) : r_cur;

    // Tail position: head plus count, folded once
    assign w_tail_sum = (PW+1)'(r_head[w_q]) + (PW+1)'(r_cnt[w_q]);
    assign w_tail     = (w_tail_sum >= (PW+1)'(QUEUE_DEPTH))
                      ? PW'(w_tail_sum - (PW+1)'(QUEUE_DEPTH)) : PW'(w_tail_sum);
    assign w_head_nx  = (r_head[w_q] == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head[w_q] + 1'b1;
    assign w_slot_head = AW'(32'(w_q) * QUEUE_DEPTH + 32'(r_head[w_q]));
    assign w_slot_tail = AW'(32'(w_q) * QUEUE_DEPTH + 32'(w_tail));

    assign w_full = (r_cnt[w_q] >= CW'(QUEUE_DEPTH));
    assign w_drop = (32'(r_req.queue_index) >= 32'(NUM_QUEUES)) || w_full;
    assign w_wrap = (r_cur == QW'(NUM_QUEUES - 1));

    // Saturate time at all ones, deficit at the largest positive value
    assign w_tsat = (w_sum[AL-1:32] != '0) ? 32'hFFFF_FFFF : w_sum[31:0];
    assign w_dsat = (!w_sum[AL-1] && (w_sum[32:31] != 2'b00))
                  ? 32'sh7FFF_FFFF : w_sum[31:0];

    drr_alu u_alu (
        .i_a   (w_a),
        .i_b   (w_b),
        .i_c   (w_c),
        .o_sum (w_sum),
        .o_lt  (w_lt)
    );

    drr_mem #(
        .DEPTH (SLOTS),
        .AW    (AW),
        .WIDTH (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            drr_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_req.data.op == drr_pkg::OP_ENQ) begin
                        n_state = drr_pkg::S_ENQ;
                    end else if (r_pend == '0) begin
                        n_state = drr_pkg::S_DONE;
                    end else begin
                        n_state = drr_pkg::S_VISIT;
                    end
                end
            end
            drr_pkg::S_ENQ: n_state = drr_pkg::S_DONE;
            drr_pkg::S_VISIT: begin
                if (r_visits == drr_pkg::VISIT_LIMIT) begin
                    n_state = drr_pkg::S_DONE;
                end else if (r_cnt[w_q] == '0) begin
                    n_state = drr_pkg::S_MOVE;
                end else begin
                    n_state = drr_pkg::S_ARR;
                end
            end
            drr_pkg::S_ARR:   n_state = w_lt ? drr_pkg::S_MOVE : drr_pkg::S_FIT;
            drr_pkg::S_FIT:   n_state = w_lt ? drr_pkg::S_QADD : drr_pkg::S_WAIT;
            drr_pkg::S_WAIT:  n_state = drr_pkg::S_DSUB;
            drr_pkg::S_DSUB:  n_state = drr_pkg::S_VSIZE;
            drr_pkg::S_VSIZE: n_state = drr_pkg::S_DONE;
            drr_pkg::S_QADD:  n_state = drr_pkg::S_ROT;
            drr_pkg::S_ROT:   n_state = drr_pkg::S_MOVE;
            drr_pkg::S_MOVE:  n_state = w_wrap ? drr_pkg::S_WRAP : drr_pkg::S_VISIT;
            drr_pkg::S_WRAP:  n_state = drr_pkg::S_VISIT;
            drr_pkg::S_DONE:  n_state = w_out_free ? drr_pkg::S_IDLE : drr_pkg::S_DONE;
            default:          n_state = drr_pkg::S_IDLE;
        endcase
    end

    // Datapath controls: adder operands and store ports
    always_comb begin
        w_a     = AL'(signed'({2'b00, r_vt}));
        w_b     = '0;
        w_c     = '0;
        w_we    = 1'b0;
        w_waddr = w_slot_tail;
        w_wdata = {1'b0, r_req.arrival_time, r_req.pkt_len};
        w_re    = 1'b0;
        w_raddr = w_slot_head;
        unique case (r_state)
            drr_pkg::S_ENQ: begin
                w_we = !w_drop;
            end
            drr_pkg::S_VISIT: begin
                w_re = 1'b1;
            end
            drr_pkg::S_ARR: begin
                // vt + tolerance < arrival: head not yet eligible
                w_b = AL'(signed'({1'b0, r_tol}));
                w_c = AL'(signed'({2'b00, w_pkt.arr}));
            end
            drr_pkg::S_FIT: begin
                // deficit + tolerance < size: head does not fit
                w_a = AL'(r_def[w_q]);
                w_b = AL'(signed'({1'b0, r_tol}));
                w_c = AL'(signed'({1'b0, w_pkt.size}));
            end
            drr_pkg::S_WAIT: begin
                w_b = -AL'(signed'({2'b00, w_pkt.arr}));
            end
            drr_pkg::S_DSUB: begin
                w_a = AL'(r_def[w_q]);
                w_b = -AL'(signed'({1'b0, w_pkt.size}));
            end
            drr_pkg::S_VSIZE: begin
                w_b = AL'(signed'({1'b0, w_pkt.size}));
            end
            drr_pkg::S_QADD: begin
                w_a = AL'(r_def[w_q]);
                w_b = AL'(signed'({1'b0, r_quant[2'(w_q)]}));
            end
            drr_pkg::S_ROT: begin
                // Head goes back in at the tail, marked retried
                w_we    = 1'b1;
                w_wdata = {1'b1, w_pkt.arr, w_pkt.size};
            end
            drr_pkg::S_MOVE, drr_pkg::S_WRAP: begin
                w_b = AL'(signed'({1'b0, r_sw}));
            end
            default: begin
            end
        endcase
    end

    // Control and queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= drr_pkg::S_IDLE;
            r_vt     <= '0;
            r_cur    <= '0;
            r_pend   <= '0;
            r_visits <= '0;
            for (int i = 0; i < NUM_QUEUES; i++) begin
                r_head[i] <= '0;
                r_cnt[i]  <= '0;
                r_def[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                drr_pkg::S_IDLE: begin
                    r_visits <= '0;
                end
                drr_pkg::S_ENQ: begin
                    if (!w_drop) begin
                        r_cnt[w_q] <= r_cnt[w_q] + 1'b1;
                        r_pend     <= r_pend + 1'b1;
                    end
                end
                drr_pkg::S_VISIT: begin
                    if (r_visits != drr_pkg::VISIT_LIMIT) begin
                        r_visits <= r_visits + 1'b1;
                    end
                end
                drr_pkg::S_DSUB: begin
                    r_def[w_q] <= w_sum[31:0];
                end
                drr_pkg::S_VSIZE: begin
                    r_vt         <= w_tsat;
                    r_head[w_q]  <= w_head_nx;
                    r_cnt[w_q]   <= r_cnt[w_q] - 1'b1;
                    r_pend       <= r_pend - 1'b1;
                end
                drr_pkg::S_QADD: begin
                    r_def[w_q] <= w_dsat;
                end
                drr_pkg::S_ROT: begin
                    // Pop and push at once: count is unchanged
                    r_head[w_q] <= w_head_nx;
                end
                drr_pkg::S_MOVE: begin
                    r_vt  <= w_tsat;
                    r_cur <= w_wrap ? '0 : r_cur + 1'b1;
                end
                drr_pkg::S_WRAP: begin
                    r_vt <= w_tsat;
                end
                default: begin
                end
            endcase
        end
    end

    // Request hold and result fields
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req.data;
            r_kind  <= drr_pkg::KIND_NONE;
            r_sq    <= '0;
            r_sarr  <= '0;
            r_wait  <= '0;
            r_retry <= 1'b0;
        end else if (r_state == drr_pkg::S_ENQ) begin
            r_kind <= w_drop ? drr_pkg::KIND_DROP : drr_pkg::KIND_ENQ;
        end else if (r_state == drr_pkg::S_WAIT) begin
            r_kind  <= drr_pkg::KIND_SERVED;
            r_sq    <= 2'(w_q);
            r_sarr  <= w_pkt.arr;
            r_wait  <= w_sum[AL-1] ? '0 : w_sum[31:0];
            r_retry <= w_pkt.retry;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == drr_pkg::S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == drr_pkg::S_DONE && w_out_free) begin
            r_rsp.kind           <= r_kind;
            r_rsp.served_queue   <= r_sq;
            r_rsp.served_arrival <= r_sarr;
            r_rsp.wait_time      <= r_wait;
            r_rsp.was_retried    <= r_retry;
            r_rsp.now_time       <= r_vt;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_quant[i] <= 16'd1;
            end
            r_sw  <= '0;
            r_tol <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                drr_pkg::CFG_QUANTUM0, drr_pkg::CFG_QUANTUM1,
                drr_pkg::CFG_QUANTUM2, drr_pkg::CFG_QUANTUM3: begin
                    r_quant[i_cfg_idx[1:0]] <= i_cfg_wdata;
                end
                drr_pkg::CFG_SWITCH: r_sw  <= i_cfg_wdata;
                drr_pkg::CFG_TOL:    r_tol <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == drr_pkg::S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

endmodule

FILE: design/drr_chk.sv
// ----------------------------------------------------------------------------
// Deficit round robin port checker
// Watches the top level's ports; bound to the top level.
// ----------------------------------------------------------------------------
`include "deficit_round_robin_scheduler_top_macros.svh"

module drr_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input drr_pkg::t_drr_rsp i_out_data
);
    logic w_in_acc;
    logic w_served;

    assign w_in_acc = i_in_valid && i_in_ready;
    assign w_served = i_out_valid && (i_out_data.kind == drr_pkg::KIND_SERVED);

    `DRR_ASSERT_NXT(a_busy_after_req, i_clk, i_rst_n, w_in_acc, !i_in_ready, "ready while busy")
    `DRR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "stalled result changed")
    `DRR_ASSERT_IMP(a_unserved_zero, i_clk, i_rst_n, i_out_valid && !w_served, (i_out_data.served_queue == '0) && (i_out_data.wait_time == '0) && (i_out_data.served_arrival == '0) && !i_out_data.was_retried, "unserved result has service fields")
    `DRR_ASSERT_IMP(a_wait_bound, i_clk, i_rst_n, w_served, i_out_data.wait_time <= i_out_data.now_time, "wait exceeds time")
endmodule

bind deficit_round_robin_scheduler_top drr_chk u_drr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_data  (o_rsp.data)
);

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Deficit round robin scheduler testbench
// Drives enqueue and serve requests over the valid/ready request channel,
// predicts every result with an independent scheduler model in virtual time,
// and compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NQ = 4;
    localparam int DEPTH = 16;
    localparam int WALK_LIMIT = 4096;
    localparam longint DEF_MAX = 64'sd2147483647;
    localparam longint CYCLE_LIMIT = 100000000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [drr_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [drr_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    drr_req_if req_ch ();
    drr_rsp_if rsp_ch ();

    deficit_round_robin_scheduler_top #(
        .NUM_QUEUES (NQ),
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Clock: 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Scheduler shadow state: packet store, FIFO pointers, deficits and time.
    // ------------------------------------------------------------------------
    bit [15:0] pkt_size [NQ][DEPTH];
    bit [31:0] pkt_arr [NQ][DEPTH];
    bit        pkt_retry [NQ][DEPTH];
    int        q_head [NQ];
    int        q_count [NQ];
    longint    q_deficit [NQ];
    bit [31:0] vtime;
    int        cur_q;
    int        pending;

    bit [15:0] quantum [NQ];
    bit [15:0] switch_cost;
    bit [7:0]  tolerance;

    drr_pkg::t_drr_req  request_q [$];   // requests waiting for the driver
    drr_pkg::t_drr_rsp  outcome_q [$];   // predicted results, oldest first

    int  send_idle_pct;
    int  recv_stall_pct;
    bit  req_taken;
    int  errors;
    int  n_requests;
    int  n_served;
    int  n_dropped;
    int  n_nothing;
    longint cycles;

    function automatic bit [31:0] time_add(bit [31:0] a, longint b);
        longint s;
        s = longint'(a) + b;
        return (s > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Advance to the next queue; wrapping costs the switch time once more.
    function automatic void next_queue();
        vtime = time_add(vtime, switch_cost);
        cur_q++;
        if (cur_q >= NQ) begin
            cur_q = 0;
            vtime = time_add(vtime, switch_cost);
        end
    endfunction

    function automatic drr_pkg::t_drr_rsp schedule(drr_pkg::t_drr_req r);
        drr_pkg::t_drr_rsp res;
        int slot_i;
        int c;
        bit [15:0] sz;
        bit [31:0] arr;
        res = '0;
        if (drr_pkg::t_op'(r.op) == drr_pkg::OP_ENQ) begin
            c = r.queue_index;
            if (q_count[c] >= DEPTH) begin
                res.kind = drr_pkg::KIND_DROP;
            end else begin
                slot_i = (q_head[c] + q_count[c]) % DEPTH;
                pkt_size[c][slot_i] = r.pkt_len;
                pkt_arr[c][slot_i] = r.arrival_time;
                pkt_retry[c][slot_i] = 1'b0;
                q_count[c]++;
                pending++;
                res.kind = drr_pkg::KIND_ENQ;
            end
            res.now_time = vtime;
            return res;
        end
        res.kind = drr_pkg::KIND_NONE;
        if (pending != 0) begin
            for (int v = 0; v < WALK_LIMIT; v++) begin
                c = cur_q;
                if (q_count[c] == 0) begin
                    next_queue();
                    continue;
                end
                slot_i = q_head[c];
                if (longint'(vtime) + longint'(tolerance)
                        < longint'(pkt_arr[c][slot_i])) begin
                    next_queue();
                    continue;
                end
                if (longint'(pkt_size[c][slot_i]) <= q_deficit[c] + longint'(tolerance)) begin
                    res.kind = drr_pkg::KIND_SERVED;
                    res.served_queue = c[1:0];
                    res.served_arrival = pkt_arr[c][slot_i];
                    res.wait_time = (vtime > pkt_arr[c][slot_i]) ?
                                    vtime - pkt_arr[c][slot_i] : 32'd0;
                    res.was_retried = pkt_retry[c][slot_i];
                    q_deficit[c] -= longint'(pkt_size[c][slot_i]);
                    vtime = time_add(vtime, pkt_size[c][slot_i]);
                    q_head[c] = (q_head[c] + 1) % DEPTH;
                    q_count[c]--;
                    pending--;
                    break;
                end
                // Too big for the deficit: credit the quantum, rotate the head.
                sz = pkt_size[c][slot_i];
                arr = pkt_arr[c][slot_i];
                q_deficit[c] += longint'(quantum[c]);
                if (q_deficit[c] > DEF_MAX)
                    q_deficit[c] = DEF_MAX;
                q_head[c] = (q_head[c] + 1) % DEPTH;
                q_count[c]--;
                slot_i = (q_head[c] + q_count[c]) % DEPTH;
                pkt_size[c][slot_i] = sz;
                pkt_arr[c][slot_i] = arr;
                pkt_retry[c][slot_i] = 1'b1;
                q_count[c]++;
                next_queue();
            end
        end
        res.now_time = vtime;
        return res;
    endfunction

    // Queue a request and its predicted result.
    task automatic post(drr_pkg::t_op op, int q, bit [15:0] sz, bit [31:0] arr);
        drr_pkg::t_drr_req r;
        r.op = op;
        r.queue_index = q[1:0];
        r.pkt_len = sz;
        r.arrival_time = arr;
        request_q = {request_q, r};
        outcome_q = {outcome_q, schedule(r)};
        n_requests++;
    endtask

    // Write one register at the falling edge; the block is idle here.
    task automatic write_reg(drr_pkg::t_cfg_idx idx, bit [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            drr_pkg::CFG_SWITCH: switch_cost = val;
            drr_pkg::CFG_TOL:    tolerance = val[7:0];
            default:             quantum[int'(idx)] = val;
        endcase
    endtask

    task automatic set_quanta(int lo, int hi);
        for (int q = 0; q < NQ; q++)
            write_reg(drr_pkg::t_cfg_idx'(int'(drr_pkg::CFG_QUANTUM0) + q),
                      16'($urandom_range(hi, lo)));
    endtask

    // Wait until every result has arrived, then let the block settle.
    task automatic drain();
        while (outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic random_traffic(int n, bit far_arrivals);
        bit [15:0] sz;
        bit [31:0] arr;
        int pick;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 45) begin
                post(drr_pkg::OP_SERVE, $urandom_range(3), 16'($urandom), $urandom);
                continue;
            end
            pick = $urandom_range(99);
            if (pick < 70)      sz = 16'($urandom_range(2000));
            else if (pick < 90) sz = 16'($urandom);
            else                sz = ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
            pick = $urandom_range(99);
            if (far_arrivals && pick < 3)
                arr = $urandom;
            else if (pick < 80)
                arr = time_add(vtime, $urandom_range(3000));
            else
                arr = (vtime > 32'd5000) ? vtime - 32'($urandom_range(5000)) : 32'd0;
            post(drr_pkg::OP_ENQ, $urandom_range(3), sz, arr);
        end
    endtask

    // Mismatch report: one line, one count.
    task automatic report(string field, longint got, longint want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h",
                 $realtime, field, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: present requests at the falling edge, with random idle gaps.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
        end else begin
            // Hold a request until it is taken; then load the next or idle.
            if (!req_ch.valid || req_taken) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_ch.valid <= 1'b1;
                    req_ch.data <= request_q.pop_front();
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample handshakes at the rising edge and check each result.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        drr_pkg::t_drr_rsp want;
        drr_pkg::t_drr_rsp got;
        req_taken = i_rst_n && req_ch.valid && req_ch.ready;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            if (outcome_q.size() == 0) begin
                report("unexpected result", got.now_time, 0);
            end else begin
                want = outcome_q.pop_front();
                if (got.kind !== want.kind)
                    report("kind", got.kind, want.kind);
                if (got.served_queue !== want.served_queue)
                    report("served_queue", got.served_queue, want.served_queue);
                if (got.served_arrival !== want.served_arrival)
                    report("served_arrival", got.served_arrival, want.served_arrival);
                if (got.wait_time !== want.wait_time)
                    report("wait_time", got.wait_time, want.wait_time);
                if (got.was_retried !== want.was_retried)
                    report("was_retried", got.was_retried, want.was_retried);
                if (got.now_time !== want.now_time)
                    report("now_time", got.now_time, want.now_time);
                case (drr_pkg::t_kind'(want.kind))
                    drr_pkg::KIND_SERVED: n_served++;
                    drr_pkg::KIND_DROP:   n_dropped++;
                    drr_pkg::KIND_NONE:   n_nothing++;
                    default:              ;
                endcase
            end
        end
    end

    // Watchdog: give up well beyond the slowest legal run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     outcome_q.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------------
    initial begin
        int tries;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        req_taken = 1'b0;
        errors = 0;
        cycles = 0;
        vtime = '0;
        cur_q = 0;
        pending = 0;
        switch_cost = '0;
        tolerance = '0;
        for (int q = 0; q < NQ; q++) begin
            q_head[q] = 0;
            q_count[q] = 0;
            q_deficit[q] = 0;
            quantum[q] = 16'd1;
        end
        send_idle_pct = 13;
        recv_stall_pct = 86;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty serve, size extremes, a queue filled past its depth.
        post(drr_pkg::OP_SERVE, 0, 16'h0, 32'h0);
        post(drr_pkg::OP_ENQ, 0, 16'h0000, 32'h0);
        post(drr_pkg::OP_SERVE, 0, 16'h0, 32'h0);
        post(drr_pkg::OP_ENQ, 2, 16'hFFFF, 32'h0);
        post(drr_pkg::OP_SERVE, 0, 16'h0, 32'h0);
        for (int i = 0; i < 17; i++)
            post(drr_pkg::OP_ENQ, 1, 16'($urandom_range(3)), 32'h0);
        post(drr_pkg::OP_SERVE, 0, 16'h0, 32'h0);
        drain();

        // Phase one: moderate quanta, no switch cost, sender mostly busy.
        set_quanta(1000, 8000);
        write_reg(drr_pkg::CFG_SWITCH, 16'd0);
        write_reg(drr_pkg::CFG_TOL, 8'd0);
        random_traffic(420, 1'b0);
        drain();

        // Phase two: maximum quanta, switch cost and slack; receiver busy.
        send_idle_pct = 86;
        recv_stall_pct = 13;
        set_quanta(65535, 65535);
        write_reg(drr_pkg::CFG_SWITCH, 16'hFFFF);
        write_reg(drr_pkg::CFG_TOL, 8'hFF);
        random_traffic(420, 1'b1);
        drain();

        // Phase three: mixed settings, no idling at all.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_quanta(1, 20000);
        write_reg(drr_pkg::CFG_SWITCH, 16'($urandom_range(300)));
        write_reg(drr_pkg::CFG_TOL, 8'($urandom));
        random_traffic(420, 1'b0);
        drain();

        // Zero quanta: oversized heads only rotate until the walk gives up.
        set_quanta(0, 0);
        write_reg(drr_pkg::CFG_TOL, 8'd0);
        write_reg(drr_pkg::CFG_SWITCH, 16'd0);
        post(drr_pkg::OP_ENQ, 3, 16'hFFFF, vtime);
        post(drr_pkg::OP_SERVE, 0, 16'h0, 32'h0);
        drain();

        // Far future arrival: serve until virtual time saturates and it goes.
        write_reg(drr_pkg::CFG_SWITCH, 16'hFFFF);
        set_quanta(65535, 65535);
        post(drr_pkg::OP_ENQ, 0, 16'hFFFF, 32'hFFFF_FFFF);
        tries = 0;
        do begin
            post(drr_pkg::OP_SERVE, 0, 16'h0, 32'h0);
            tries++;
        end while (pending != 0 && tries < 60);
        post(drr_pkg::OP_SERVE, 0, 16'h0, 32'h0);
        drain();

        $display("%0d requests: %0d served, %0d dropped, %0d with nothing to serve",
                 n_requests, n_served, n_dropped, n_nothing);
        $display("final virtual time 0x%0h, %0d mismatches", vtime, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
